// File: hw/rtl/lazy_ntt_butterfly_52bit_macros.svh
// ---------------------------------------------------------------------------
// Lazy NTT butterfly assertion macros
// Concurrent check helpers shared by the butterfly RTL.
// ---------------------------------------------------------------------------
`ifndef LAZY_NTT_BUTTERFLY_52BIT_MACROS_SVH
`define LAZY_NTT_BUTTERFLY_52BIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define LNTT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LNTT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/lntt_pkg.sv
// ---------------------------------------------------------------------------
// Lazy NTT butterfly package
// Shared widths, op codes, register indexes and the side-data type.
// ---------------------------------------------------------------------------
package lntt_pkg;

   // default Shoup word width
   localparam int WORD_BITS_DEF = 52;

   // fixed field widths
   localparam int FIELD_BITS = 52;
   localparam int Q_BITS     = 50;
   localparam int OP_BITS    = 2;

   // op codes
   localparam logic [OP_BITS-1:0] OP_FWD  = 2'd0;
   localparam logic [OP_BITS-1:0] OP_INV  = 2'd1;
   localparam logic [OP_BITS-1:0] OP_LAST = 2'd2;

   // configuration register indexes
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODULUS         = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_N_INVERSE       = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_N_INVERSE_PRE   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_N_INVERSE_TW    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_N_INVERSE_TW_PRE = 3'd4;

   localparam logic [Q_BITS-1:0] MODULUS_RESET = 50'd2;

   // pipeline depth from input register to output register
   localparam int STAGES = 10;

   // data that rides beside the multipliers
   typedef struct packed {
      logic [OP_BITS-1:0]    op;
      logic [FIELD_BITS-1:0] xr;    // x folded into [0,2q)
      logic [FIELD_BITS-1:0] s;     // x+y folded into [0,2q)
   } side_type;

endpackage

// File: hw/rtl/lazy_ntt_butterfly_52bit.sv
// ---------------------------------------------------------------------------
// Lazy NTT butterfly, 52-bit Shoup form
// Forward, inverse and scaled last-inverse butterflies over a prime q < 2^50.
// ---------------------------------------------------------------------------
// Usage:
//   Load modulus and the n^-1 constants through the csr_ port while the
//   block is idle; each write with csr_write high lands at the clock edge.
//   Input pairs arrive on req_ (op, x, y, twiddle, twiddle precon) and the
//   butterfly outputs leave on rsp_. A transfer happens when valid is high
//   and stall is low.
//   rsp_valid rises once an input transfer has passed all ten register
//   stages: two operand stages, two three-stage multipliers in series
//   (quotient, then reduction), the final add and the output register.
//   Throughput: one transfer per cycle while req_stall is low. Each stage
//   carries its own valid bit and only holds when it is full and the stage
//   after it holds, so bubbles are squeezed out and inputs keep flowing
//   while a result waits. When rsp_stall holds the output, req_stall rises
//   only once all ten stages are full.
//   Reset (synchronous) empties the pipeline and returns the registers to
//   modulus 2 and zero constants.
// ---------------------------------------------------------------------------
`include "lazy_ntt_butterfly_52bit_macros.svh"

module lazy_ntt_butterfly_52bit #(
   parameter int WORD_BITS = lntt_pkg::WORD_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // configuration
   input  logic                                   csr_write,
   input  logic [lntt_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [lntt_pkg::FIELD_BITS-1:0]        csr_data,
   // input channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [lntt_pkg::OP_BITS-1:0]           req_op,
   input  logic [lntt_pkg::FIELD_BITS-1:0]        req_x_in,
   input  logic [lntt_pkg::FIELD_BITS-1:0]        req_y_in,
   input  logic [lntt_pkg::Q_BITS-1:0]            req_twiddle,
   input  logic [lntt_pkg::FIELD_BITS-1:0]        req_twiddle_precon,
   // result channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [lntt_pkg::FIELD_BITS-1:0]        rsp_x_out,
   output logic [lntt_pkg::FIELD_BITS-1:0]        rsp_y_out
);

   localparam int W  = WORD_BITS;
   localparam int NS = lntt_pkg::STAGES;
   localparam int FB = lntt_pkg::FIELD_BITS;
   localparam int QB = lntt_pkg::Q_BITS;

   // configuration registers
   logic [QB-1:0] modulus_ff;
   logic [QB-1:0] n_inverse_ff;
   logic [FB-1:0] n_inverse_precon_ff;
   logic [QB-1:0] n_inverse_twiddle_ff;
   logic [FB-1:0] n_inverse_twiddle_precon_ff;

   logic [63:0]   negq64;
   logic [W-1:0]  negq;
   logic [FB-2:0] q2;

   // pipeline control
   logic [NS-1:0] vld_ff, vld_in, en;

   // datapath
   lntt_pkg::side_type side1;
   lntt_pkg::side_type side_ff [7];
   lntt_pkg::side_type side8;
   logic [W-1:0]  v_a, m_a, mp_a, v_b, m_b, mp_b;
   logic [W-1:0]  t_a, t_b;
   logic [63:0]   t_a64, t_b64, ta_red64, tb_red64;
   logic [FB-1:0] tb52;
   logic [FB-1:0] rsp_x_out_in, rsp_y_out_in;
   logic [FB-1:0] rsp_x_out_ff, rsp_y_out_ff;

   // write configuration registers; drop writes beyond the list
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff                  <= lntt_pkg::MODULUS_RESET;
         n_inverse_ff                <= '0;
         n_inverse_precon_ff         <= '0;
         n_inverse_twiddle_ff        <= '0;
         n_inverse_twiddle_precon_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            lntt_pkg::CSR_MODULUS:          modulus_ff <= csr_data[QB-1:0];
            lntt_pkg::CSR_N_INVERSE:        n_inverse_ff <= csr_data[QB-1:0];
            lntt_pkg::CSR_N_INVERSE_PRE:    n_inverse_precon_ff <= csr_data;
            lntt_pkg::CSR_N_INVERSE_TW:     n_inverse_twiddle_ff <= csr_data[QB-1:0];
            lntt_pkg::CSR_N_INVERSE_TW_PRE: n_inverse_twiddle_precon_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // derived modulus forms
   assign negq64 = 64'd0 - 64'(modulus_ff);
   assign negq   = negq64[W-1:0];
   assign q2     = {modulus_ff, 1'b0};

   // advance a stage when it is empty or the stage after it advances
   always_comb begin
      en[NS-1] = !vld_ff[NS-1] || !rsp_stall;
      for (int i = NS - 2; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
   end

   assign vld_in = {vld_ff[NS-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NS; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   assign req_stall = !en[0];

   // operand preparation: stages 0 and 1
   lntt_prep #(.W(W)) u_prep (
      .clock                    (clock),
      .en                       (en[1:0]),
      .op                       (req_op),
      .x_in                     (req_x_in),
      .y_in                     (req_y_in),
      .twiddle                  (req_twiddle),
      .twiddle_precon           (req_twiddle_precon),
      .modulus                  (modulus_ff),
      .n_inverse                (n_inverse_ff),
      .n_inverse_precon         (n_inverse_precon_ff),
      .n_inverse_twiddle        (n_inverse_twiddle_ff),
      .n_inverse_twiddle_precon (n_inverse_twiddle_precon_ff),
      .side                     (side1),
      .v_a                      (v_a),
      .m_a                      (m_a),
      .mp_a                     (mp_a),
      .v_b                      (v_b),
      .m_b                      (m_b),
      .mp_b                     (mp_b)
   );

   // Shoup multipliers: stages 2 through 8
   lntt_shoup #(.W(W)) u_shoup_a (
      .clock  (clock),
      .en     (en[8:2]),
      .v      (v_a),
      .m      (m_a),
      .mp     (mp_a),
      .negq   (negq),
      .result (t_a)
   );

   lntt_shoup #(.W(W)) u_shoup_b (
      .clock  (clock),
      .en     (en[8:2]),
      .v      (v_b),
      .m      (m_b),
      .mp     (mp_b),
      .negq   (negq),
      .result (t_b)
   );

   // carry op and folded operands beside the multipliers
   always_ff @(posedge clock) begin
      if (en[2]) begin
         side_ff[0] <= side1;
      end
      for (int i = 1; i < 7; i++) begin
         if (en[i+2]) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign side8 = side_ff[6];

   // final correction and output select
   assign t_a64    = 64'(t_a);
   assign t_b64    = 64'(t_b);
   assign tb52     = t_b64[FB-1:0];
   assign ta_red64 = (t_a64 >= 64'(modulus_ff)) ? (t_a64 - 64'(modulus_ff)) : t_a64;
   assign tb_red64 = (t_b64 >= 64'(modulus_ff)) ? (t_b64 - 64'(modulus_ff)) : t_b64;

   always_comb begin
      rsp_x_out_in = '0;
      rsp_y_out_in = '0;
      case (side8.op)
         lntt_pkg::OP_FWD: begin
            rsp_x_out_in = side8.xr + tb52;
            rsp_y_out_in = side8.xr + FB'(q2) - tb52;
         end
         lntt_pkg::OP_INV: begin
            rsp_x_out_in = side8.s;
            rsp_y_out_in = tb52;
         end
         lntt_pkg::OP_LAST: begin
            rsp_x_out_in = ta_red64[FB-1:0];
            rsp_y_out_in = tb_red64[FB-1:0];
         end
         default: begin
         end
      endcase
   end

   // output register: stage 9
   always_ff @(posedge clock) begin
      if (en[NS-1]) begin
         rsp_x_out_ff <= rsp_x_out_in;
         rsp_y_out_ff <= rsp_y_out_in;
      end
   end

   assign rsp_valid = vld_ff[NS-1];
   assign rsp_x_out = rsp_x_out_ff;
   assign rsp_y_out = rsp_y_out_ff;

   // assertions
   `LNTT_ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && !req_stall, vld_ff[0], "accepted transfer did not enter the first stage")
   `LNTT_ASSERT_SAME(a_stall_when_full, clock, reset, req_stall, (&vld_ff) && rsp_stall, "input stalled with room in the pipeline")
   `LNTT_ASSERT_NEXT(a_reset_flush, clock, 1'b0, reset, vld_ff == '0, "pipeline not empty after reset")

endmodule

// File: hw/rtl/lntt_mul.sv
// ---------------------------------------------------------------------------
// Pipelined unsigned multiplier
// Full W x W product in three stages: half-word partials, middle sum,
// final combine.
// ---------------------------------------------------------------------------
module lntt_mul #(
   parameter int W = lntt_pkg::WORD_BITS_DEF
) (
   input  logic           clock,
   input  logic [2:0]     en,
   input  logic [W-1:0]   a,
   input  logic [W-1:0]   b,
   output logic [2*W-1:0] prod
);

   localparam int H  = (W + 1) / 2;
   localparam int HB = W - H;
   localparam int PW = 2 * W;

   logic [H-1:0]    a_lo, b_lo;
   logic [HB-1:0]   a_hi, b_hi;
   logic [2*H-1:0]  p00_in, p01_in, p10_in, p11_in;
   logic [2*H-1:0]  p00_ff, p01_ff, p10_ff, p11_ff;
   logic [2*H:0]    mid_in, mid_ff;
   logic [2*H-1:0]  p00b_ff, p11b_ff;
   logic [PW-1:0]   prod_in, prod_ff;

   assign a_lo = a[H-1:0];
   assign a_hi = a[W-1:H];
   assign b_lo = b[H-1:0];
   assign b_hi = b[W-1:H];

   // form half-word partial products
   assign p00_in = (2*H)'(a_lo) * (2*H)'(b_lo);
   assign p01_in = (2*H)'(a_lo) * (2*H)'(b_hi);
   assign p10_in = (2*H)'(a_hi) * (2*H)'(b_lo);
   assign p11_in = (2*H)'(a_hi) * (2*H)'(b_hi);

   // add the cross terms
   assign mid_in = (2*H+1)'(p01_ff) + (2*H+1)'(p10_ff);

   // combine into the full product
   assign prod_in = PW'(p00b_ff) + (PW'(mid_ff) << H) + (PW'(p11b_ff) << (2*H));

   always_ff @(posedge clock) begin
      if (en[0]) begin
         p00_ff <= p00_in;
         p01_ff <= p01_in;
         p10_ff <= p10_in;
         p11_ff <= p11_in;
      end
      if (en[1]) begin
         mid_ff  <= mid_in;
         p00b_ff <= p00_ff;
         p11b_ff <= p11_ff;
      end
      if (en[2]) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

// File: hw/rtl/lntt_prep.sv
// ---------------------------------------------------------------------------
// Butterfly operand preparation
// Two stages: fold x, form x+y and x-y+2q, then fold the sum and steer
// operands and constants to the two Shoup multipliers.
// ---------------------------------------------------------------------------
module lntt_prep #(
   parameter int W = lntt_pkg::WORD_BITS_DEF
) (
   input  logic                              clock,
   input  logic [1:0]                        en,
   input  logic [lntt_pkg::OP_BITS-1:0]      op,
   input  logic [lntt_pkg::FIELD_BITS-1:0]   x_in,
   input  logic [lntt_pkg::FIELD_BITS-1:0]   y_in,
   input  logic [lntt_pkg::Q_BITS-1:0]       twiddle,
   input  logic [lntt_pkg::FIELD_BITS-1:0]   twiddle_precon,
   input  logic [lntt_pkg::Q_BITS-1:0]       modulus,
   input  logic [lntt_pkg::Q_BITS-1:0]       n_inverse,
   input  logic [lntt_pkg::FIELD_BITS-1:0]   n_inverse_precon,
   input  logic [lntt_pkg::Q_BITS-1:0]       n_inverse_twiddle,
   input  logic [lntt_pkg::FIELD_BITS-1:0]   n_inverse_twiddle_precon,
   output lntt_pkg::side_type                side,
   output logic [W-1:0]                      v_a,
   output logic [W-1:0]                      m_a,
   output logic [W-1:0]                      mp_a,
   output logic [W-1:0]                      v_b,
   output logic [W-1:0]                      m_b,
   output logic [W-1:0]                      mp_b
);

   localparam int FB = lntt_pkg::FIELD_BITS;

   logic [FB-2:0]  q2;
   logic [63:0]    t64, y64, w64, wp64;
   logic [63:0]    s64, ni64, nip64, nit64, nitp64;

   logic [lntt_pkg::OP_BITS-1:0] op1_ff;
   logic [FB-1:0]  xr1_in, xr1_ff;
   logic [FB:0]    sum1_in, sum1_ff;
   logic [W-1:0]   t1_ff, y1_ff, w1_ff, wp1_ff;

   logic [FB:0]    s2;
   lntt_pkg::side_type side_in, side_ff;
   logic [W-1:0]   v_a_in, m_a_in, mp_a_in, v_b_in, m_b_in, mp_b_in;
   logic [W-1:0]   v_a_ff, m_a_ff, mp_a_ff, v_b_ff, m_b_ff, mp_b_ff;

   assign q2 = {modulus, 1'b0};

   // stage 1: fold x, sum and lifted difference
   assign xr1_in  = (x_in >= FB'(q2)) ? (x_in - FB'(q2)) : x_in;
   assign sum1_in = (FB+1)'(x_in) + (FB+1)'(y_in);
   assign t64     = 64'(x_in) - 64'(y_in) + 64'(q2);
   assign y64     = 64'(y_in);
   assign w64     = 64'(twiddle);
   assign wp64    = 64'(twiddle_precon);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         op1_ff  <= op;
         xr1_ff  <= xr1_in;
         sum1_ff <= sum1_in;
         t1_ff   <= t64[W-1:0];
         y1_ff   <= y64[W-1:0];
         w1_ff   <= w64[W-1:0];
         wp1_ff  <= wp64[W-1:0];
      end
   end

   // stage 2: fold the sum, steer multiplier operands
   assign s2     = (sum1_ff >= (FB+1)'(q2)) ? (sum1_ff - (FB+1)'(q2)) : sum1_ff;
   assign s64    = 64'(s2);
   assign ni64   = 64'(n_inverse);
   assign nip64  = 64'(n_inverse_precon);
   assign nit64  = 64'(n_inverse_twiddle);
   assign nitp64 = 64'(n_inverse_twiddle_precon);

   always_comb begin
      side_in.op = op1_ff;
      side_in.xr = xr1_ff;
      side_in.s  = s2[FB-1:0];
      v_a_in  = '0;
      m_a_in  = '0;
      mp_a_in = '0;
      v_b_in  = '0;
      m_b_in  = '0;
      mp_b_in = '0;
      case (op1_ff)
         lntt_pkg::OP_FWD: begin
            v_b_in  = y1_ff;
            m_b_in  = w1_ff;
            mp_b_in = wp1_ff;
         end
         lntt_pkg::OP_INV: begin
            v_b_in  = t1_ff;
            m_b_in  = w1_ff;
            mp_b_in = wp1_ff;
         end
         lntt_pkg::OP_LAST: begin
            v_a_in  = s64[W-1:0];
            m_a_in  = ni64[W-1:0];
            mp_a_in = nip64[W-1:0];
            v_b_in  = t1_ff;
            m_b_in  = nit64[W-1:0];
            mp_b_in = nitp64[W-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         side_ff <= side_in;
         v_a_ff  <= v_a_in;
         m_a_ff  <= m_a_in;
         mp_a_ff <= mp_a_in;
         v_b_ff  <= v_b_in;
         m_b_ff  <= m_b_in;
         mp_b_ff <= mp_b_in;
      end
   end

   assign side = side_ff;
   assign v_a  = v_a_ff;
   assign m_a  = m_a_ff;
   assign mp_a = mp_a_ff;
   assign v_b  = v_b_ff;
   assign m_b  = m_b_ff;
   assign mp_b = mp_b_ff;

endmodule

// File: hw/rtl/lntt_shoup.sv
// ---------------------------------------------------------------------------
// Shoup modular multiplier
// Computes (v*m - hi(mp*v)*q) mod 2^W in seven stages: quotient and low
// product in parallel, then quotient times -q, then the final add.
// ---------------------------------------------------------------------------
module lntt_shoup #(
   parameter int W = lntt_pkg::WORD_BITS_DEF
) (
   input  logic         clock,
   input  logic [6:0]   en,
   input  logic [W-1:0] v,
   input  logic [W-1:0] m,
   input  logic [W-1:0] mp,
   input  logic [W-1:0] negq,
   output logic [W-1:0] result
);

   logic [2*W-1:0] p_hi, p_lo, p_red;
   logic [W-1:0]   qt;
   logic [W-1:0]   lo_ff [3];
   logic [W-1:0]   res_in, res_ff;

   // quotient estimate and low product
   lntt_mul #(.W(W)) u_mul_quot (
      .clock (clock),
      .en    (en[2:0]),
      .a     (mp),
      .b     (v),
      .prod  (p_hi)
   );

   lntt_mul #(.W(W)) u_mul_low (
      .clock (clock),
      .en    (en[2:0]),
      .a     (m),
      .b     (v),
      .prod  (p_lo)
   );

   assign qt = p_hi[2*W-1:W];

   // quotient times -q
   lntt_mul #(.W(W)) u_mul_red (
      .clock (clock),
      .en    (en[5:3]),
      .a     (qt),
      .b     (negq),
      .prod  (p_red)
   );

   // carry the low product alongside the reduction multiply
   always_ff @(posedge clock) begin
      if (en[3]) begin
         lo_ff[0] <= p_lo[W-1:0];
      end
      if (en[4]) begin
         lo_ff[1] <= lo_ff[0];
      end
      if (en[5]) begin
         lo_ff[2] <= lo_ff[1];
      end
   end

   // final add modulo 2^W
   assign res_in = p_red[W-1:0] + lo_ff[2];

   always_ff @(posedge clock) begin
      if (en[6]) begin
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

endmodule
